/* design/ace_pkg.sv */
// shared types, character constants and decimal digit helper for the cell stream encoder
// no dependencies
package ace_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RST,
      ST_CSI,
      ST_FLAGS,
      ST_FGHDR,
      ST_FGCOL,
      ST_BGHDR,
      ST_BGCOL,
      ST_SGR_END,
      ST_GLYPH,
      ST_ROWHDR,
      ST_ROWNUM,
      ST_ROWD
   } state_type;

   typedef struct packed {
      logic       load;
      logic       emit;
      state_type  state;
      logic [3:0] cnt;
   } cmd_type;

   typedef struct packed {
      logic drop;
      logic mask_nz;
      logic fg_chg;
      logic bg_chg;
      logic sep_fg;
      logic sep_bg;
      logic row_end;
      logic flag_last;
      logic out_free;
   } sts_type;

   localparam logic [7:0] CH_ESC  = 8'h1B;
   localparam logic [7:0] CH_LBR  = 8'h5B;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_ONE  = 8'h31;
   localparam logic [7:0] CH_TWO  = 8'h32;
   localparam logic [7:0] CH_THR  = 8'h33;
   localparam logic [7:0] CH_FOUR = 8'h34;
   localparam logic [7:0] CH_EIGH = 8'h38;
   localparam logic [7:0] CH_LC_M = 8'h6D;
   localparam logic [7:0] CH_B    = 8'h42;
   localparam logic [7:0] CH_D    = 8'h44;

   localparam logic [7:0] FLAG_CODE [6] = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h38, 8'h39};

   // ascii digit of a byte, pos 0 = hundreds, 1 = tens, 2 = ones
   function automatic logic [7:0] dec_digit(input logic [7:0] v, input logic [1:0] pos);
      logic [1:0]  h;
      logic [6:0]  r;
      logic [14:0] p;
      logic [3:0]  t;
      logic [3:0]  o;
      logic [6:0]  tr;
      h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
      r = 7'(v - 8'(h) * 8'd100);
      // divide by ten through reciprocal, exact below 1029
      p = 15'(r) * 15'd205;
      t = 4'(p >> 11);
      tr = 7'(t) * 7'd10;
      o = 4'(r - tr);
      case (pos)
         2'd0:    dec_digit = CH_ZERO + 8'(h);
         2'd1:    dec_digit = CH_ZERO + 8'(t);
         default: dec_digit = CH_ZERO + 8'(o);
      endcase
   endfunction

endpackage

/* design/ace_ctrl.sv */
// sequencer walking the escape sequence segments of one cell
// depends on ace_pkg
module ace_ctrl import ace_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type  state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   state_type  after_csi;
   logic [3:0] fg_start, bg_start;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign fg_start = sts.sep_fg ? 4'd0 : 4'd1;
   assign bg_start = sts.sep_bg ? 4'd0 : 4'd1;

   always_comb begin
      if (sts.mask_nz)     after_csi = ST_FLAGS;
      else if (sts.fg_chg) after_csi = ST_FGHDR;
      else if (sts.bg_chg) after_csi = ST_BGHDR;
      else                 after_csi = ST_SGR_END;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            // status is registered at load, decided in the first busy cycle
            if (req_valid) begin
               state_in = ST_CSI;
               cnt_in   = 4'd15;
            end
         end
         default: begin
            if (state_ff == ST_CSI && cnt_ff == 4'd15) begin
               // decision cycle, no byte emitted
               cnt_in = '0;
               if (sts.drop)
                  state_in = ST_RST;
               else if (sts.mask_nz || sts.fg_chg || sts.bg_chg)
                  state_in = ST_CSI;
               else
                  state_in = ST_GLYPH;
            end else if (sts.out_free) begin
               cnt_in = cnt_ff + 4'd1;
               case (state_ff)
                  ST_RST: if (cnt_ff == 4'd3) begin
                     state_in = ST_CSI;
                     cnt_in   = '0;
                  end
                  ST_CSI: if (cnt_ff == 4'd1) begin
                     state_in = after_csi;
                     cnt_in   = (after_csi == ST_FGHDR) ? fg_start :
                                (after_csi == ST_BGHDR) ? bg_start : 4'd0;
                  end
                  ST_FLAGS: if (sts.flag_last) begin
                     if (sts.fg_chg) begin
                        state_in = ST_FGHDR;
                        cnt_in   = fg_start;
                     end else if (sts.bg_chg) begin
                        state_in = ST_BGHDR;
                        cnt_in   = bg_start;
                     end else begin
                        state_in = ST_SGR_END;
                        cnt_in   = '0;
                     end
                  end
                  ST_FGHDR: if (cnt_ff == 4'd5) begin
                     state_in = ST_FGCOL;
                     cnt_in   = '0;
                  end
                  ST_FGCOL: if (cnt_ff == 4'd10) begin
                     state_in = sts.bg_chg ? ST_BGHDR : ST_SGR_END;
                     cnt_in   = sts.bg_chg ? bg_start : 4'd0;
                  end
                  ST_BGHDR: if (cnt_ff == 4'd5) begin
                     state_in = ST_BGCOL;
                     cnt_in   = '0;
                  end
                  ST_BGCOL: if (cnt_ff == 4'd10) begin
                     state_in = ST_SGR_END;
                     cnt_in   = '0;
                  end
                  ST_SGR_END: begin
                     state_in = ST_GLYPH;
                     cnt_in   = '0;
                  end
                  ST_GLYPH: begin
                     state_in = sts.row_end ? ST_ROWHDR : ST_IDLE;
                     cnt_in   = '0;
                  end
                  ST_ROWHDR: if (cnt_ff == 4'd5) begin
                     state_in = ST_ROWNUM;
                     cnt_in   = '0;
                  end
                  ST_ROWNUM: if (cnt_ff == 4'd2) begin
                     state_in = ST_ROWD;
                     cnt_in   = '0;
                  end
                  default: begin
                     state_in = ST_IDLE;
                     cnt_in   = '0;
                  end
               endcase
            end
         end
      endcase
   end

   // outputs
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      cmd.load  = (state_ff == ST_IDLE) && req_valid;
      cmd.emit  = (state_ff != ST_IDLE) && sts.out_free &&
                  !(state_ff == ST_CSI && cnt_ff == 4'd15);
      cmd.state = state_ff;
      cmd.cnt   = cnt_ff;
   end

endmodule

/* design/ace_dpath.sv */
// cell registers, delta compare, byte selection and output word register
// depends on ace_pkg
module ace_dpath import ace_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [7:0]  req_glyph,
   input  logic [7:0]  req_attr_flags,
   input  logic [23:0] req_fg_color,
   input  logic [23:0] req_bg_color,
   input  logic        req_image_start,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_byte
);

   logic [7:0]  width_ff;
   logic [7:0]  pflags_ff;
   logic [23:0] pfg_ff, pbg_ff;
   logic [7:0]  col_ff;
   logic [7:0]  glyph_ff;
   logic [23:0] fg_ff, bg_ff;
   logic [5:0]  mask_ff;
   logic        sep_ff;
   logic        drop_ff, fgc_ff, bgc_ff, rowend_ff;
   logic        vld_ff;
   logic [7:0]  byte_ff;
   logic        last_ff;

   logic [7:0]  ef;
   logic [23:0] efg, ebg;
   logic [7:0]  ecol, ncol;
   logic        drop;
   logic [5:0]  low, rem;
   logic [2:0]  low_idx;
   logic [23:0] color;
   logic [7:0]  comp;
   logic [7:0]  obyte;
   logic        olast;

   // previous state as seen by this cell
   assign ef   = req_image_start ? ~req_attr_flags : pflags_ff;
   assign efg  = req_image_start ? 24'd0 : pfg_ff;
   assign ebg  = req_image_start ? 24'd0 : pbg_ff;
   assign ecol = req_image_start ? 8'd0 : col_ff;
   assign drop = |(ef & ~req_attr_flags);
   assign ncol = ecol + 8'd1;

   assign low = mask_ff & (~mask_ff + 6'd1);
   assign rem = mask_ff & ~low;
   always_comb begin
      low_idx = '0;
      for (int i = 5; i >= 0; i--) begin
         if (mask_ff[i]) low_idx = 3'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 8'd1;
         pflags_ff <= '0;
         pfg_ff    <= '0;
         pbg_ff    <= '0;
         col_ff    <= '0;
         vld_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) width_ff <= csr_wr_data;
         if (cmd.load) begin
            pflags_ff <= req_attr_flags;
            pfg_ff    <= req_fg_color;
            pbg_ff    <= req_bg_color;
            col_ff    <= (ncol == width_ff) ? 8'd0 : ncol;
         end
         if (cmd.emit)           vld_ff <= 1'b1;
         else if (!rsp_stall)    vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         glyph_ff  <= req_glyph;
         fg_ff     <= req_fg_color;
         bg_ff     <= req_bg_color;
         drop_ff   <= drop;
         mask_ff   <= drop ? req_attr_flags[5:0] : (req_attr_flags[5:0] & ~ef[5:0]);
         sep_ff    <= 1'b0;
         fgc_ff    <= drop || (req_fg_color != efg);
         bgc_ff    <= drop || (req_bg_color != ebg);
         rowend_ff <= (ncol == width_ff);
      end else if (cmd.emit && cmd.state == ST_FLAGS) begin
         if (sep_ff) begin
            sep_ff <= 1'b0;
         end else begin
            mask_ff <= rem;
            sep_ff  <= (rem != 6'd0);
         end
      end
      if (cmd.emit) begin
         byte_ff <= obyte;
         last_ff <= olast;
      end
   end

   assign color = (cmd.state == ST_FGCOL) ? fg_ff : bg_ff;
   always_comb begin
      case (cmd.cnt[3:2])
         2'd0:    comp = color[23:16];
         2'd1:    comp = color[15:8];
         default: comp = color[7:0];
      endcase
   end

   always_comb begin
      obyte = CH_SEMI;
      case (cmd.state)
         ST_RST: begin
            case (cmd.cnt[1:0])
               2'd0:    obyte = CH_ESC;
               2'd1:    obyte = CH_LBR;
               2'd2:    obyte = CH_ZERO;
               default: obyte = CH_LC_M;
            endcase
         end
         ST_CSI:   obyte = cmd.cnt[0] ? CH_LBR : CH_ESC;
         ST_FLAGS: obyte = sep_ff ? CH_SEMI : FLAG_CODE[low_idx];
         ST_FGHDR, ST_BGHDR: begin
            case (cmd.cnt[2:0])
               3'd1:    obyte = (cmd.state == ST_FGHDR) ? CH_THR : CH_FOUR;
               3'd2:    obyte = CH_EIGH;
               3'd4:    obyte = CH_TWO;
               default: obyte = CH_SEMI;
            endcase
         end
         ST_FGCOL, ST_BGCOL: begin
            obyte = (cmd.cnt[1:0] == 2'd3) ? CH_SEMI : dec_digit(comp, cmd.cnt[1:0]);
         end
         ST_SGR_END: obyte = CH_LC_M;
         ST_GLYPH:   obyte = glyph_ff;
         ST_ROWHDR: begin
            case (cmd.cnt[2:0])
               3'd0, 3'd4: obyte = CH_ESC;
               3'd2:       obyte = CH_ONE;
               3'd3:       obyte = CH_B;
               default:    obyte = CH_LBR;
            endcase
         end
         ST_ROWNUM: obyte = dec_digit(width_ff, cmd.cnt[1:0]);
         ST_ROWD:   obyte = CH_D;
         default:   obyte = CH_SEMI;
      endcase
   end

   assign olast = (cmd.state == ST_ROWD) || (cmd.state == ST_GLYPH && !rowend_ff);

   always_comb begin
      sts.drop      = drop_ff;
      sts.mask_nz   = (mask_ff != 6'd0);
      sts.fg_chg    = fgc_ff;
      sts.bg_chg    = bgc_ff;
      sts.sep_fg    = drop_ff || (mask_ff != 6'd0);
      sts.sep_bg    = drop_ff || (mask_ff != 6'd0) || fgc_ff;
      sts.row_end   = rowend_ff;
      sts.flag_last = !sep_ff && (rem == 6'd0);
      sts.out_free  = !vld_ff || !rsp_stall;
   end

   assign rsp_valid     = vld_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_last_byte = last_ff;

endmodule

/* design/ansi_cell_stream_encoder_core.sv */
// ansi cell stream encoder: one cell in, a stream of escape-coded bytes out
// one byte per cycle while the output side takes words; a cell gives n output bytes
// (n from 1 to 63), walked by the byte-serial segment sequencer
// the first byte passes the cell registers, a decision state and the output register;
// the next cell is taken once the last byte is in the output register
// synchronous active-high reset: previous attributes, colors and column cleared, width 1
module ansi_cell_stream_encoder_core import ace_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_glyph,
   input  logic [7:0]  req_attr_flags,
   input  logic [23:0] req_fg_color,
   input  logic [23:0] req_bg_color,
   input  logic        req_image_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_byte,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   ace_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ace_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_glyph       (req_glyph),
      .req_attr_flags  (req_attr_flags),
      .req_fg_color    (req_fg_color),
      .req_bg_color    (req_bg_color),
      .req_image_start (req_image_start),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

endmodule

/* test/ansi_cell_stream_encoder_core_tb.sv */
// testbench for the ansi cell stream encoder: drives cells, predicts the byte stream
// depends on ace_pkg and ansi_cell_stream_encoder_core
`timescale 1ns / 1ps

class ansi_byte_board;
   logic [7:0] width_q;
   logic [7:0] last_flags;
   logic [23:0] last_fg;
   logic [23:0] last_bg;
   logic [7:0] col_q;
   logic [8:0] pending[$];
   int errors;

   function void clear();
      width_q = 8'd1;
      last_flags = 8'd0;
      last_fg = 24'd0;
      last_bg = 24'd0;
      col_q = 8'd0;
      errors = 0;
      pending.delete();
   endfunction

   function void add_byte(ref logic [7:0] b[$], input logic [7:0] v);
      b.insert(b.size(), v);
   endfunction

   function void push_dec(ref logic [7:0] b[$], input logic [7:0] v);
      add_byte(b, 8'(8'h30 + v / 8'd100));
      add_byte(b, 8'(8'h30 + (v / 8'd10) % 8'd10));
      add_byte(b, 8'(8'h30 + v % 8'd10));
   endfunction

   function void push_color(ref logic [7:0] b[$], input logic [23:0] c);
      push_dec(b, c[23:16]);
      add_byte(b, ace_pkg::CH_SEMI);
      push_dec(b, c[15:8]);
      add_byte(b, ace_pkg::CH_SEMI);
      push_dec(b, c[7:0]);
   endfunction

   function int push_flags(ref logic [7:0] b[$], input logic [7:0] f);
      int n;
      n = 0;
      for (int i = 0; i < 6; i++) begin
         if (f[i]) begin
            if (n != 0) add_byte(b, ace_pkg::CH_SEMI);
            add_byte(b, ace_pkg::FLAG_CODE[i]);
            n++;
         end
      end
      return n;
   endfunction

   function void push_text(ref logic [7:0] b[$], input string s);
      for (int i = 0; i < s.len(); i++) add_byte(b, s[i]);
   endfunction

   function void note_cell(logic [7:0] glyph, logic [7:0] flags, logic [23:0] fg,
                           logic [23:0] bg, logic start);
      logic [7:0] b[$];
      logic [7:0] col;
      int parts;
      if (start) begin
         last_flags = ~flags;
         last_fg = 24'd0;
         last_bg = 24'd0;
         col_q = 8'd0;
      end
      if ((last_flags & ~flags) != 8'd0) begin
         add_byte(b, ace_pkg::CH_ESC);
         push_text(b, "[0m");
         add_byte(b, ace_pkg::CH_ESC);
         add_byte(b, ace_pkg::CH_LBR);
         parts = push_flags(b, flags);
         push_text(b, ";38;2;");
         push_color(b, fg);
         push_text(b, ";48;2;");
         push_color(b, bg);
         add_byte(b, ace_pkg::CH_LC_M);
      end else begin
         parts = 0;
         add_byte(b, ace_pkg::CH_ESC);
         add_byte(b, ace_pkg::CH_LBR);
         if (flags != last_flags) parts = push_flags(b, flags & ~last_flags);
         if (fg != last_fg) begin
            if (parts != 0) add_byte(b, ace_pkg::CH_SEMI);
            push_text(b, "38;2;");
            push_color(b, fg);
            parts++;
         end
         if (bg != last_bg) begin
            if (parts != 0) add_byte(b, ace_pkg::CH_SEMI);
            push_text(b, "48;2;");
            push_color(b, bg);
            parts++;
         end
         if (parts != 0) add_byte(b, ace_pkg::CH_LC_M);
         else b.delete();
      end
      last_flags = flags;
      last_fg = fg;
      last_bg = bg;
      add_byte(b, glyph);
      col = col_q + 8'd1;
      if (col == width_q) begin
         add_byte(b, ace_pkg::CH_ESC);
         push_text(b, "[1B");
         add_byte(b, ace_pkg::CH_ESC);
         add_byte(b, ace_pkg::CH_LBR);
         push_dec(b, width_q);
         add_byte(b, ace_pkg::CH_D);
         col = 8'd0;
      end
      col_q = col;
      if (b.size() > 64) b = b[0:63];
      foreach (b[i]) pending.insert(pending.size(), {b[i], 1'(i == b.size() - 1)});
   endfunction

   function void check_byte(logic [7:0] data, logic last);
      logic [8:0] exp;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected word %h last %b", data, last);
         return;
      end
      exp = pending.pop_front();
      if (exp != {data, last}) begin
         errors++;
         if (errors <= 10)
            $display("mismatch: expected %h last %b, got %h last %b",
                     exp[8:1], exp[0], data, last);
      end
   endfunction
endclass

module ansi_cell_stream_encoder_core_tb;
   import ace_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_glyph;
   logic [7:0]  req_attr_flags;
   logic [23:0] req_fg_color;
   logic [23:0] req_bg_color;
   logic        req_image_start;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_byte;
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;

   ansi_cell_stream_encoder_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_glyph(req_glyph),
      .req_attr_flags(req_attr_flags), .req_fg_color(req_fg_color),
      .req_bg_color(req_bg_color), .req_image_start(req_image_start),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_byte(rsp_out_byte),
      .rsp_last_byte(rsp_last_byte), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   ansi_byte_board board;
   int send_idle_pct;
   int stall_pct;
   bit hold_off;
   int quiet_cycles;
   localparam int WATCHDOG = 20000;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stall, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_off || ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_byte(rsp_out_byte, rsp_last_byte);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic send_cell(logic [7:0] g, logic [7:0] f, logic [23:0] fg, logic [23:0] bg,
                            logic st);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_glyph <= g;
      req_attr_flags <= f;
      req_fg_color <= fg;
      req_bg_color <= bg;
      req_image_start <= st;
      do @(posedge clock); while (req_stall);
      board.note_cell(g, f, fg, bg, st);
      req_valid <= 1'b0;
      // block is busy after taking a cell, through its decision state and its bytes
      @(posedge clock);
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_width(logic [7:0] w);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.width_q = w;
   endtask

   function automatic logic [23:0] pick_color();
      case ($urandom_range(3))
         0: return 24'd0;
         1: return 24'hFFFFFF;
         default: return 24'($urandom());
      endcase
   endfunction

   task automatic random_cells(int n);
      logic [7:0] f;
      logic [23:0] fg;
      logic [23:0] bg;
      f = 8'($urandom());
      fg = pick_color();
      bg = pick_color();
      for (int i = 0; i < n; i++) begin
         // mostly small deltas so the incremental path gets exercised
         case ($urandom_range(5))
            0: f = 8'($urandom());
            1: f = f | (8'd1 << $urandom_range(7));
            2: fg = pick_color();
            3: bg = pick_color();
            default: ;
         endcase
         send_cell(8'($urandom()), f, fg, bg, $urandom_range(15) == 0);
      end
   endtask

   initial begin
      board = new();
      board.clear();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off = 1'b0;
      req_valid = 1'b0;
      req_glyph = 8'd0;
      req_attr_flags = 8'd0;
      req_fg_color = 24'd0;
      req_bg_color = 24'd0;
      req_image_start = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = 8'd0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, empty flag quirk, bits 6/7, no change
      send_cell(8'h41, 8'h00, 24'd0, 24'd0, 1'b0);
      send_cell(8'h00, 8'h3F, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
      send_cell(8'hFF, 8'h3F, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
      send_cell(8'h42, 8'h00, 24'h010203, 24'hC8641E, 1'b0);
      send_cell(8'h43, 8'hC0, 24'h010203, 24'hC8641E, 1'b0);
      send_cell(8'h44, 8'hFF, 24'h00FF00, 24'hC8641E, 1'b0);
      send_cell(8'h45, 8'h80, 24'h00FF00, 24'hFF0000, 1'b1);
      send_cell(8'h46, 8'h3F, 24'h0000FF, 24'h000000, 1'b1);
      for (int i = 0; i < 6; i++)
         send_cell(8'h30 + 8'(i), 8'd1 << i, 24'(i * 99), 24'(i * 7), i == 3);
      set_width(8'd3);
      for (int i = 0; i < 7; i++)
         send_cell(8'h61 + 8'(i), 8'($urandom()), pick_color(), pick_color(), i == 5);
      set_width(8'd255);
      random_cells(15);
      set_width(8'd4);
      send_idle_pct = 72;
      random_cells(20);
      set_width(8'd0);
      send_idle_pct = 0;
      stall_pct = 72;
      random_cells(20);
      set_width(8'd2);
      send_idle_pct = 37;
      stall_pct = 37;
      random_cells(20);
      // fill the block while the output is held back
      send_idle_pct = 0;
      stall_pct = 0;
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         random_cells(10);
      join
      drain();
      random_cells(15);
      drain();
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

/* sim.f */
design/ace_pkg.sv
design/ace_ctrl.sv
design/ace_dpath.sv
design/ansi_cell_stream_encoder_core.sv
test/ansi_cell_stream_encoder_core_tb.sv
